// File: rtl/core/ipa_pkg.sv
// ----------------------------------------------------------------------------
// ipa_pkg
// Shared types and codes of the address pool allocator: request actions,
// result status codes, register indexes and the controller/datapath link.
// ----------------------------------------------------------------------------
package ipa_pkg;

  // Request actions.
  localparam logic [2:0] ACT_INIT      = 3'd0;
  localparam logic [2:0] ACT_ALLOC     = 3'd1;
  localparam logic [2:0] ACT_FREE      = 3'd2;
  localparam logic [2:0] ACT_RESERVE   = 3'd3;
  localparam logic [2:0] ACT_UNRESERVE = 3'd4;
  localparam logic [2:0] ACT_RUN_FREE  = 3'd5;
  localparam logic [2:0] ACT_RUN_RSVD  = 3'd6;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DISABLED  = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_NO_RUN    = 3'd4;
  localparam logic [2:0] ST_OVER      = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_BASE  = 3'd0;
  localparam logic [2:0] REG_SIZE  = 3'd1;
  localparam logic [2:0] REG_MASK  = 3'd2;
  localparam logic [2:0] REG_DRAIN = 3'd3;
  localparam logic [2:0] REG_LIMIT = 3'd4;

  // Largest block size.
  localparam logic [32:0] MAX_BLOCK = 33'h0_0000_ffff;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETUP,
    OP_BSCAN,
    OP_RANGE,
    OP_SWEEP,
    OP_EVAL
  } dp_op_e;

  // Where the request goes after setup.
  typedef enum logic [1:0] {
    NX_RESULT,
    NX_READ,
    NX_BSCAN,
    NX_SWEEP
  } nxt_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    nxt_e setup_nxt;
    logic bscan_done;
    logic range_go;
    logic eval_done;
    logic sweep_last;
  } stat_t;

endpackage

// File: rtl/core/ipa_ctrl.sv
// ----------------------------------------------------------------------------
// ipa_ctrl
// Request sequencer: clearing pass after reset, setup, broadcast search,
// bitmap sweep and the read/evaluate walk, then a one-cycle result strobe.
// ----------------------------------------------------------------------------
module ipa_ctrl import ipa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  output logic  done_o,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_BSCAN,
    S_RANGE,
    S_SWEEP,
    S_READ,
    S_EVAL,
    S_RESULT
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  // Datapath operation for the current state.
  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      S_CLEAR:  cmd_o.op = OP_SWEEP;
      S_IDLE:   cmd_o.op = start ? OP_LOAD : OP_NONE;
      S_SETUP:  cmd_o.op = OP_SETUP;
      S_BSCAN:  cmd_o.op = OP_BSCAN;
      S_RANGE:  cmd_o.op = OP_RANGE;
      S_SWEEP:  cmd_o.op = OP_SWEEP;
      S_EVAL:   cmd_o.op = OP_EVAL;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  // State, busy flag and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          if (stat_i.sweep_last) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            state_q <= S_SETUP;
            busy_q  <= 1'b1;
          end
        end
        S_SETUP: begin
          case (stat_i.setup_nxt)
            NX_READ:  state_q <= S_READ;
            NX_BSCAN: state_q <= S_BSCAN;
            NX_SWEEP: state_q <= S_SWEEP;
            default: begin
              state_q <= S_RESULT;
              done_q  <= 1'b1;
            end
          endcase
        end
        S_BSCAN: begin
          if (stat_i.bscan_done) begin
            state_q <= S_RANGE;
          end
        end
        S_RANGE: begin
          if (stat_i.range_go) begin
            state_q <= S_READ;
          end else begin
            state_q <= S_RESULT;
            done_q  <= 1'b1;
          end
        end
        S_SWEEP: begin
          if (stat_i.sweep_last) begin
            state_q <= S_RESULT;
            done_q  <= 1'b1;
          end
        end
        S_READ: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (stat_i.eval_done) begin
            state_q <= S_RESULT;
            done_q  <= 1'b1;
          end else begin
            state_q <= S_READ;
          end
        end
        S_RESULT: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

// File: rtl/core/ipa_datapath.sv
// ----------------------------------------------------------------------------
// ipa_datapath
// Configuration registers, in-use and reserved bitmaps, block geometry,
// counters and the per-address evaluation of the requests.
// ----------------------------------------------------------------------------
module ipa_datapath import ipa_pkg::*; #(
  parameter int unsigned ADDR_COUNT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [2:0]  action_i,
  input  logic [31:0] address_i,
  input  logic [15:0] count_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output logic [2:0]  status_o,
  output logic [31:0] addr_out_o,
  output logic [31:0] run_end_o,
  output logic [15:0] avail_count_o,
  output logic [31:0] alloc_count_o,
  output logic [31:0] free_count_o,
  output logic [31:0] fail_count_o
);

  localparam int unsigned AW = (ADDR_COUNT > 1) ? $clog2(ADDR_COUNT) : 1;
  localparam logic [32:0] CAP = 33'(ADDR_COUNT);
  localparam logic [AW-1:0] LAST_IDX = AW'(ADDR_COUNT - 1);

  // Configuration registers.
  logic [31:0] base_q, mask_q;
  logic [15:0] bsize_q, limit_q;
  logic        drain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      bsize_q <= '0;
      mask_q  <= 32'hffff_ff00;
      drain_q <= 1'b0;
      limit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BASE:  base_q  <= cfg_data_i;
        REG_SIZE:  bsize_q <= cfg_data_i[15:0];
        REG_MASK:  mask_q  <= cfg_data_i;
        REG_DRAIN: drain_q <= cfg_data_i[0];
        REG_LIMIT: limit_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Request and walk registers.
  logic [2:0]    act_q, act_d;
  logic [31:0]   addr_q, addr_d;
  logic [15:0]   cnt_q, cnt_d;
  logic [31:0]   live_base_q, live_base_d;
  logic [15:0]   live_size_q, live_size_d;
  logic [15:0]   avail_q, avail_d;
  logic [31:0]   allocs_q, allocs_d, frees_q, frees_d, fails_q, fails_d;
  logic [15:0]   off_q, off_d, off_hi_q, off_hi_d, start_q, start_d;
  logic [31:0]   h_q, h_d, cur_q, cur_d, bc_q, bc_d;
  logic [33:0]   last_q, last_d;
  logic [4:0]    j_q, j_d;
  logic [AW-1:0] sw_q, sw_d;
  logic          mark_q, mark_d, phase_q, phase_d;
  logic [2:0]    status_q, status_d;
  logic [31:0]   aout_q, aout_d, rend_q, rend_d;

  // Bitmap memories with registered read.
  logic          used_mem [ADDR_COUNT];
  logic          rsvd_mem [ADDR_COUNT];
  logic          rd_used_q, rd_rsvd_q;
  logic          we_used, we_rsvd, wr_used, wr_rsvd;
  logic [AW-1:0] waddr, raddr;

  assign raddr = off_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we_used) begin
      used_mem[waddr] <= wr_used;
    end
    if (we_rsvd) begin
      rsvd_mem[waddr] <= wr_rsvd;
    end
    rd_used_q <= used_mem[raddr];
    rd_rsvd_q <= rsvd_mem[raddr];
  end

  // Geometry terms used by setup, search and walk.
  logic [31:0] h_cfg, miss_cfg, miss_r, bit_r, below_r, diff, lo, lastc;
  logic [32:0] edge_sz, sz_req, sz1, sz2, sz3, n_len, blk_end, hi;
  logic [15:0] size16;
  logic        over, in_blk, more, match, host_edge;

  always_comb begin
    h_cfg    = ~mask_q;
    edge_sz  = {1'b0, h_cfg} - {1'b0, base_q & h_cfg} + 33'd1;
    sz_req   = (bsize_q != 16'd0) ? {17'b0, bsize_q} : edge_sz;
    sz1      = (sz_req > edge_sz) ? edge_sz : sz_req;
    sz2      = (sz1 > MAX_BLOCK) ? MAX_BLOCK : sz1;
    sz3      = (sz2 > CAP) ? CAP : sz2;
    size16   = sz3[15:0];
    over     = (limit_q != 16'd0) && (size16 > limit_q);
    diff     = addr_q - live_base_q;
    in_blk   = diff < {16'b0, live_size_q};
    miss_cfg = h_cfg & ~addr_q;
    n_len    = (cnt_q != 16'd0) ? {17'b0, cnt_q}
                                : {1'b0, h_cfg} - {1'b0, addr_q & h_cfg} + 33'd1;
    miss_r   = h_q & ~addr_q;
    bit_r    = 32'd1 << j_q;
    below_r  = bit_r - 32'd1;
    lastc    = (last_q < {2'b0, bc_q}) ? last_q[31:0] : bc_q - 32'd1;
    lo       = (addr_q > live_base_q) ? addr_q : live_base_q;
    blk_end  = {1'b0, live_base_q} + {17'b0, live_size_q} - 33'd1;
    hi       = (blk_end > {1'b0, lastc}) ? {1'b0, lastc} : blk_end;
    more     = ({1'b0, off_q} + 17'd1) < {1'b0, live_size_q};
    match    = (act_q == ACT_RUN_RSVD) ? rd_rsvd_q : !rd_used_q;
    host_edge = ((cur_q & h_q) == 32'd0) || ((cur_q & h_q) == h_q);
  end

  // Next-state logic of the datapath.
  always_comb begin
    act_d = act_q; addr_d = addr_q; cnt_d = cnt_q;
    live_base_d = live_base_q; live_size_d = live_size_q; avail_d = avail_q;
    allocs_d = allocs_q; frees_d = frees_q; fails_d = fails_q;
    off_d = off_q; off_hi_d = off_hi_q; start_d = start_q;
    h_d = h_q; cur_d = cur_q; bc_d = bc_q; last_d = last_q; j_d = j_q;
    sw_d = sw_q; mark_d = mark_q; phase_d = phase_q;
    status_d = status_q; aout_d = aout_q; rend_d = rend_q;
    we_used = 1'b0; we_rsvd = 1'b0; wr_used = 1'b0; wr_rsvd = 1'b0;
    waddr = off_q[AW-1:0];
    stat_o = '{setup_nxt: NX_RESULT, bscan_done: 1'b0, range_go: 1'b0,
               eval_done: 1'b0, sweep_last: 1'b0};

    case (cmd_i.op)
      // Latch the request.
      OP_LOAD: begin
        act_d  = action_i;
        addr_d = address_i;
        cnt_d  = count_i;
      end

      // Decode the request and prepare its walk.
      OP_SETUP: begin
        status_d = ST_OK;
        aout_d   = '0;
        rend_d   = '0;
        phase_d  = 1'b0;
        case (act_q)
          ACT_INIT: begin
            live_size_d = over ? 16'd0 : size16;
            avail_d     = over ? 16'd0 : size16;
            live_base_d = over ? live_base_q : base_q;
            mark_d      = !over;
            status_d    = over ? ST_OVER : ST_OK;
            h_d         = h_cfg;
            cur_d       = base_q;
            sw_d        = '0;
            stat_o.setup_nxt = NX_SWEEP;
          end
          ACT_ALLOC: begin
            if (drain_q) begin
              status_d = ST_DISABLED;
            end else if (live_size_q == 16'd0) begin
              status_d = ST_EXHAUSTED;
              fails_d  = fails_q + 32'd1;
            end else begin
              off_d = '0;
              stat_o.setup_nxt = NX_READ;
            end
          end
          ACT_FREE, ACT_RUN_FREE, ACT_RUN_RSVD: begin
            if (in_blk) begin
              off_d = diff[15:0];
              stat_o.setup_nxt = NX_READ;
            end else begin
              status_d = ST_INVALID;
            end
          end
          ACT_RESERVE, ACT_UNRESERVE: begin
            h_d    = h_cfg;
            j_d    = 5'd31;
            last_d = {2'b0, addr_q} + {1'b0, n_len} - 34'd1;
            if (miss_cfg != 32'd0 && live_size_q != 16'd0) begin
              stat_o.setup_nxt = NX_BSCAN;
            end
          end
          default: status_d = ST_INVALID;
        endcase
      end

      // Find the first broadcast address at or above the range start.
      OP_BSCAN: begin
        if (miss_r[j_q]) begin
          bc_d = (addr_q & ~(below_r | bit_r)) | bit_r | (h_q & below_r);
          stat_o.bscan_done = 1'b1;
        end else begin
          j_d = j_q - 5'd1;
        end
      end

      // Clip the range to the block and to the broadcast address.
      OP_RANGE: begin
        off_d    = 16'(lo - live_base_q);
        off_hi_d = 16'(hi[31:0] - live_base_q);
        cur_d    = lo;
        stat_o.range_go = {1'b0, lo} <= hi;
      end

      // Write one bitmap entry per cycle: clear, or mark network/broadcast.
      OP_SWEEP: begin
        waddr   = sw_q;
        we_used = 1'b1;
        we_rsvd = 1'b1;
        wr_used = mark_q && ({1'b0, 16'(sw_q)} < {1'b0, live_size_q}) && host_edge;
        if (wr_used) begin
          avail_d = avail_q - 16'd1;
        end
        cur_d = cur_q + 32'd1;
        sw_d  = sw_q + AW'(1);
        if (sw_q == LAST_IDX) begin
          sw_d   = '0;
          stat_o.sweep_last = 1'b1;
        end
      end

      // Evaluate the entry read at the current offset.
      OP_EVAL: begin
        case (act_q)
          ACT_ALLOC: begin
            if (!rd_used_q) begin
              we_used  = 1'b1;
              wr_used  = 1'b1;
              allocs_d = allocs_q + 32'd1;
              avail_d  = avail_q - 16'd1;
              aout_d   = live_base_q + {16'b0, off_q};
              stat_o.eval_done = 1'b1;
            end else if (more) begin
              off_d = off_q + 16'd1;
            end else begin
              fails_d  = fails_q + 32'd1;
              status_d = ST_EXHAUSTED;
              stat_o.eval_done = 1'b1;
            end
          end
          ACT_FREE: begin
            if (rd_used_q) begin
              we_used = 1'b1;
              wr_used = 1'b0;
              frees_d = frees_q + 32'd1;
              avail_d = avail_q + 16'd1;
            end else begin
              status_d = ST_INVALID;
            end
            stat_o.eval_done = 1'b1;
          end
          ACT_RESERVE, ACT_UNRESERVE: begin
            if ((cur_q & h_q) != 32'd0) begin
              if (act_q == ACT_RESERVE && !rd_used_q) begin
                we_used = 1'b1; we_rsvd = 1'b1;
                wr_used = 1'b1; wr_rsvd = 1'b1;
                avail_d = avail_q - 16'd1;
              end else if (act_q == ACT_UNRESERVE && rd_used_q) begin
                we_used = 1'b1; we_rsvd = 1'b1;
                avail_d = avail_q + 16'd1;
              end
            end
            if (off_q == off_hi_q) begin
              stat_o.eval_done = 1'b1;
            end else begin
              off_d = off_q + 16'd1;
              cur_d = cur_q + 32'd1;
            end
          end
          default: begin
            // Run queries: look for the first match, then for its end.
            if (!phase_q) begin
              if (match) begin
                start_d = off_q;
                phase_d = 1'b1;
                if (more) begin
                  off_d = off_q + 16'd1;
                end else begin
                  aout_d = live_base_q + {16'b0, off_q};
                  rend_d = live_base_q + {16'b0, off_q};
                  stat_o.eval_done = 1'b1;
                end
              end else if (more) begin
                off_d = off_q + 16'd1;
              end else begin
                status_d = ST_NO_RUN;
                stat_o.eval_done = 1'b1;
              end
            end else if (match && more) begin
              off_d = off_q + 16'd1;
            end else begin
              aout_d = live_base_q + {16'b0, start_q};
              rend_d = live_base_q + {16'b0, off_q} - (match ? 32'd0 : 32'd1);
              stat_o.eval_done = 1'b1;
            end
          end
        endcase
      end

      default: ;
    endcase
  end

  // Control state and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_base_q <= '0;
      live_size_q <= '0;
      avail_q     <= '0;
      allocs_q    <= '0;
      frees_q     <= '0;
      fails_q     <= '0;
      sw_q        <= '0;
      mark_q      <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      live_base_q <= live_base_d;
      live_size_q <= live_size_d;
      avail_q     <= avail_d;
      allocs_q    <= allocs_d;
      frees_q     <= frees_d;
      fails_q     <= fails_d;
      sw_q        <= sw_d;
      mark_q      <= mark_d;
      phase_q     <= phase_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    addr_q   <= addr_d;
    cnt_q    <= cnt_d;
    off_q    <= off_d;
    off_hi_q <= off_hi_d;
    start_q  <= start_d;
    h_q      <= h_d;
    cur_q    <= cur_d;
    bc_q     <= bc_d;
    last_q   <= last_d;
    j_q      <= j_d;
    status_q <= status_d;
    aout_q   <= aout_d;
    rend_q   <= rend_d;
  end

  assign status_o      = status_q;
  assign addr_out_o    = aout_q;
  assign run_end_o     = rend_q;
  assign avail_count_o = avail_q;
  assign alloc_count_o = allocs_q;
  assign free_count_o  = frees_q;
  assign fail_count_o  = fails_q;

endmodule

// File: rtl/core/ip_address_pool_allocator.sv
// ----------------------------------------------------------------------------
// ip_address_pool_allocator
// Bitmap allocator for one IPv4 address block with in-use and reserved maps.
// ----------------------------------------------------------------------------
// Init writes one bitmap entry per cycle. Alloc, free, reserve and run queries
// read each address visited from memory, then evaluate it, after setup; range
// requests add a broadcast search first. One request at a time; the result
// strobe lasts one cycle and the receiver cannot stall. After reset the bitmaps
// are cleared in a pass over every entry while busy is high.
module ip_address_pool_allocator import ipa_pkg::*; #(
  parameter int unsigned ADDR_COUNT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action_i,
  input  logic [31:0] address_i,
  input  logic [15:0] count_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] addr_out_o,
  output logic [31:0] run_end_o,
  output logic [15:0] avail_count_o,
  output logic [31:0] alloc_count_o,
  output logic [31:0] free_count_o,
  output logic [31:0] fail_count_o
);

  cmd_t  cmd;
  stat_t stat;

  // Request sequencer.
  ipa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // Bitmaps, registers and counters.
  ipa_datapath #(
    .ADDR_COUNT (ADDR_COUNT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .action_i      (action_i),
    .address_i     (address_i),
    .count_i       (count_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .status_o      (status_o),
    .addr_out_o    (addr_out_o),
    .run_end_o     (run_end_o),
    .avail_count_o (avail_count_o),
    .alloc_count_o (alloc_count_o),
    .free_count_o  (free_count_o),
    .fail_count_o  (fail_count_o)
  );

endmodule

// File: verif/tb_ip_address_pool_allocator.sv
// ----------------------------------------------------------------------------
// tb_ip_address_pool_allocator
// Self-checking testbench of the bitmap address pool allocator. A predictor
// in the bench keeps its own copy of both bitmaps, the block size and the
// counters. It computes every result and compares it field by field with the
// transfer seen on the result strobe. A directed part covers all actions and
// their corner cases. Random phases with varying sender gaps and register
// settings follow.
// ----------------------------------------------------------------------------
module tb_ip_address_pool_allocator;
  import ipa_pkg::*;

  localparam int unsigned ADDR_COUNT = 1024;
  localparam logic [2:0] ACT_UNKNOWN = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] addr_out;
    logic [31:0] run_end;
    logic [15:0] avail;
    logic [31:0] allocs;
    logic [31:0] frees;
    logic [31:0] fails;
  } pool_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  action_i = '0;
  logic [31:0] address_i = '0;
  logic [15:0] count_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] addr_out_o, run_end_o;
  logic [15:0] avail_count_o;
  logic [31:0] alloc_count_o, free_count_o, fail_count_o;

  // Predicted state of the block.
  logic [31:0] reg_base, reg_mask;
  logic [15:0] reg_size, reg_limit;
  logic        reg_drain;
  logic        used_bits[ADDR_COUNT];
  logic        rsvd_bits[ADDR_COUNT];
  logic [31:0] live_base;
  int unsigned live_size;
  logic [15:0] avail_total;
  logic [31:0] alloc_total, free_total, fail_total;

  pool_result_t pending_results[$];
  int unsigned  mismatches = 0;
  int unsigned  results_seen = 0;
  int unsigned  requests_sent = 0;
  int unsigned  idle_pct = 0;

  ip_address_pool_allocator #(.ADDR_COUNT(ADDR_COUNT)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .start, .busy,
    .action_i, .address_i, .count_i, .done_o, .status_o, .addr_out_o,
    .run_end_o, .avail_count_o, .alloc_count_o, .free_count_o, .fail_count_o
  );

  always #1 clk_i = ~clk_i;

  // Smallest address at or above v whose host bits are all ones.
  function automatic logic [31:0] bcast_at_or_above(logic [31:0] v, logic [31:0] h);
    logic [31:0] miss, top, below;
    int j;
    miss = h & ~v;
    if (miss == '0) return v;
    j = 31;
    while (!miss[j]) j--;
    top = 32'h1 << j;
    below = top - 1;
    return (v & ~(below | top)) | top | (h & below);
  endfunction

  // Set up a fresh block from the current registers.
  function automatic logic [2:0] init_block();
    logic [31:0] h, host;
    logic [63:0] edge_len, size;
    h = ~reg_mask;
    edge_len = {32'h0, h} - {32'h0, reg_base & h} + 1;
    size = (reg_size != 0) ? {48'h0, reg_size} : edge_len;
    if (size > edge_len) size = edge_len;
    if (size > 64'hffff) size = 64'hffff;
    if (size > ADDR_COUNT) size = ADDR_COUNT;
    for (int i = 0; i < ADDR_COUNT; i++) begin
      used_bits[i] = 1'b0;
      rsvd_bits[i] = 1'b0;
    end
    live_size = 0;
    avail_total = '0;
    if (reg_limit != 0 && size > {48'h0, reg_limit}) return ST_OVER;
    live_base = reg_base;
    live_size = size[31:0];
    avail_total = size[15:0];
    for (int unsigned off = 0; off < live_size; off++) begin
      host = (live_base + off) & h;
      if (host == '0 || host == h) begin
        used_bits[off] = 1'b1;
        avail_total--;
      end
    end
    return ST_OK;
  endfunction

  // Reserve or unreserve a range, skipping network addresses.
  function automatic void walk_range(logic [31:0] first, logic [15:0] cnt, logic set);
    logic [31:0] h;
    logic [63:0] n, last, bc, lo, hi, off;
    h = ~reg_mask;
    n = (cnt != 0) ? {48'h0, cnt} : ({32'h0, h} - {32'h0, first & h} + 1);
    last = {32'h0, first} + n - 1;
    bc = {32'h0, bcast_at_or_above(first, h)};
    if (bc == {32'h0, first} || live_size == 0) return;
    if (last > bc - 1) last = bc - 1;
    if (last > 64'hffff_ffff) last = 64'hffff_ffff;
    lo = (first > live_base) ? {32'h0, first} : {32'h0, live_base};
    hi = {32'h0, live_base} + live_size - 1;
    if (hi > last) hi = last;
    for (logic [63:0] a = lo; a <= hi; a++) begin
      off = a - {32'h0, live_base};
      if (off >= ADDR_COUNT) break;
      if ((a[31:0] & h) == '0) continue;
      if (set && !used_bits[off]) begin
        used_bits[off] = 1'b1;
        rsvd_bits[off] = 1'b1;
        avail_total--;
      end else if (!set && used_bits[off]) begin
        used_bits[off] = 1'b0;
        rsvd_bits[off] = 1'b0;
        avail_total++;
      end
    end
  endfunction

  function automatic logic run_match(int unsigned off, logic rsvd);
    return rsvd ? rsvd_bits[off] : !used_bits[off];
  endfunction

  // Apply one request to the predicted state and return its result.
  function automatic pool_result_t predict_request(logic [2:0] act, logic [31:0] adr,
                                                   logic [15:0] cnt);
    pool_result_t r;
    logic [31:0] off32;
    int unsigned off, s;
    logic rsvd;
    r = '0;
    case (act)
      ACT_INIT: r.status = init_block();
      ACT_ALLOC: begin
        if (reg_drain) begin
          r.status = ST_DISABLED;
        end else begin
          off = 0;
          while (off < live_size && off < ADDR_COUNT && used_bits[off]) off++;
          if (off < live_size && off < ADDR_COUNT) begin
            used_bits[off] = 1'b1;
            alloc_total++;
            avail_total--;
            r.addr_out = live_base + off;
          end else begin
            fail_total++;
            r.status = ST_EXHAUSTED;
          end
        end
      end
      ACT_FREE: begin
        off32 = adr - live_base;
        if (off32 < live_size && off32 < ADDR_COUNT && used_bits[off32]) begin
          used_bits[off32] = 1'b0;
          free_total++;
          avail_total++;
        end else begin
          r.status = ST_INVALID;
        end
      end
      ACT_RESERVE, ACT_UNRESERVE: walk_range(adr, cnt, act == ACT_RESERVE);
      ACT_RUN_FREE, ACT_RUN_RSVD: begin
        rsvd = (act == ACT_RUN_RSVD);
        off32 = adr - live_base;
        if (off32 >= live_size || off32 >= ADDR_COUNT) begin
          r.status = ST_INVALID;
        end else begin
          off = off32;
          while (off < live_size && !run_match(off, rsvd)) off++;
          if (off >= live_size) begin
            r.status = ST_NO_RUN;
          end else begin
            s = off;
            while (off < live_size && run_match(off, rsvd)) off++;
            r.addr_out = live_base + s;
            r.run_end = live_base + off - 1;
          end
        end
      end
      default: r.status = ST_INVALID;
    endcase
    r.avail = avail_total;
    r.allocs = alloc_total;
    r.frees = free_total;
    r.fails = fail_total;
    return r;
  endfunction

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk_i) begin
    pool_result_t got, want;
    if (rst_ni && done_o) begin
      got = '{status_o, addr_out_o, run_end_o, avail_count_o, alloc_count_o,
              free_count_o, fail_count_o};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Send one request and record its prediction once the block takes it.
  // Busy is looked at on the falling edge, where it is stable.
  task automatic send_request(logic [2:0] act, logic [31:0] adr, logic [15:0] cnt);
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    action_i = act;
    address_i = adr;
    count_i = cnt;
    start = 1'b1;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    pending_results.push_back(predict_request(act, adr, cnt));
    requests_sent++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Write one register once every pending result has arrived.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    start = 1'b0;
    wait (pending_results.size() == 0);
    repeat (8) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_BASE:  reg_base = value;
      REG_SIZE:  reg_size = value[15:0];
      REG_MASK:  reg_mask = value;
      REG_DRAIN: reg_drain = value[0];
      REG_LIMIT: reg_limit = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_block(logic [31:0] base, logic [15:0] size, logic [31:0] mask,
                           logic drain, logic [15:0] limit);
    write_reg(REG_BASE, base);
    write_reg(REG_SIZE, {16'h0, size});
    write_reg(REG_MASK, mask);
    write_reg(REG_DRAIN, {31'h0, drain});
    write_reg(REG_LIMIT, {16'h0, limit});
  endtask

  // All actions, the status codes but the over-limit one, and the register extremes.
  task automatic test_directed();
    set_block(32'hc0a8_0100, 16'h0, 32'hffff_ff00, 1'b0, 16'h0);
    send_request(ACT_INIT, '0, '0);
    repeat (3) send_request(ACT_ALLOC, '0, '0);
    send_request(ACT_FREE, 32'hc0a8_0101, '0);
    send_request(ACT_FREE, 32'hc0a8_0101, '0);
    send_request(ACT_FREE, 32'h0a00_0001, '0);
    send_request(ACT_RESERVE, 32'hc0a8_010a, 16'd5);
    send_request(ACT_RUN_FREE, 32'hc0a8_0100, '0);
    send_request(ACT_RUN_RSVD, 32'hc0a8_0100, '0);
    send_request(ACT_UNRESERVE, 32'hc0a8_010a, 16'h0);
    send_request(ACT_RUN_RSVD, 32'hc0a8_0100, '0);
    send_request(ACT_UNKNOWN, 32'hffff_ffff, 16'hffff);
    send_request(ACT_RUN_FREE, 32'hc0a8_0200, '0);
    // A tiny block runs dry, then drain blocks allocation.
    set_block(32'hc0a8_0100, 16'd8, 32'hffff_ff00, 1'b0, 16'h0);
    send_request(ACT_INIT, '0, '0);
    repeat (8) send_request(ACT_ALLOC, '0, '0);
    write_reg(REG_DRAIN, 32'h1);
    send_request(ACT_ALLOC, '0, '0);
    // A pool limit above the block size, then the all-ones and all-zero extremes.
    set_block(32'hffff_ffff, 16'hffff, 32'hffff_ffff, 1'b0, 16'd4);
    send_request(ACT_INIT, '0, '0);
    set_block(32'hffff_fff0, 16'h0, 32'h0, 1'b0, 16'hffff);
    send_request(ACT_INIT, '0, '0);
    send_request(ACT_RESERVE, 32'hffff_fff8, 16'hffff);
    send_request(ACT_RUN_RSVD, 32'hffff_fff0, '0);
  endtask

  // Random register settings and requests, with a given sender gap rate.
  task automatic test_random(int unsigned pct, int unsigned n_items);
    logic [2:0] act;
    logic [31:0] adr, mask, base;
    logic [15:0] cnt, size, limit;
    int unsigned pick, k;
    idle_pct = pct;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 80 == 0) begin
        k = $urandom_range(0, 32);
        mask = (k == 32) ? 32'h0 : ~((32'h1 << k) - 1);
        if ($urandom_range(0, 9) == 0) mask = $urandom;
        base = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom & mask) + $urandom_range(0, 3);
        size = $urandom_range(1, 48);
        if ($urandom_range(0, 7) == 0) size = ($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0;
        limit = ($urandom_range(0, 4) == 0) ? $urandom : 16'h0;
        set_block(base, size, mask, $urandom_range(0, 9) == 0, limit);
        send_request(ACT_INIT, $urandom, $urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) act = ACT_INIT;
      else if (pick < 33) act = ACT_ALLOC;
      else if (pick < 58) act = ACT_FREE;
      else if (pick < 68) act = ACT_RESERVE;
      else if (pick < 78) act = ACT_UNRESERVE;
      else if (pick < 88) act = ACT_RUN_FREE;
      else if (pick < 98) act = ACT_RUN_RSVD;
      else act = ACT_UNKNOWN;
      adr = ($urandom_range(0, 9) == 0) ? $urandom
          : live_base + $urandom_range(0, live_size + 2) - 1;
      cnt = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 20);
      send_request(act, adr, cnt);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    reg_base = '0; reg_size = '0; reg_mask = 32'hffff_ff00; reg_drain = 1'b0;
    reg_limit = '0;
    void'(init_block());
    // After reset no block exists yet.
    live_base = '0;
    live_size = 0;
    avail_total = '0;
    alloc_total = '0; free_total = '0; fail_total = '0;
    test_directed();
    test_random(0, 470);
    test_random(49, 470);
    test_random(49, 470);
    test_random(38, 470);
    start = 1'b0;
    wait (pending_results.size() == 0);
    repeat (64) @(posedge clk_i);
    $display("Covered %0d requests and %0d results over all actions,", requests_sent,
             results_seen);
    $display("random register settings and sender gap rates; %0d mismatches.", mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog against a hung block.
  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
